### hw/rtl/pfc_pkg.sv
// Shared types, constants and square-geometry helpers for the Playfair digram cipher.
package pfc_pkg;

  localparam int LET_W    = 5;
  localparam int MODE_W   = 3;
  localparam int SQ_SIDE  = 5;
  localparam int SQ_CELLS = SQ_SIDE * SQ_SIDE;
  localparam int ALPHA    = 26;

  localparam logic [LET_W-1:0] LET_I    = 5'd8;
  localparam logic [LET_W-1:0] LET_J    = 5'd9;
  localparam logic [LET_W-1:0] LET_X    = 5'd23;
  localparam logic [LET_W-1:0] LET_LAST = 5'(ALPHA - 1);
  localparam logic [LET_W-1:0] CELLS_N  = 5'(SQ_CELLS);

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR    = 3'd0,
    MODE_KEY      = 3'd1,
    MODE_KEY_DONE = 3'd2,
    MODE_ENC      = 3'd3,
    MODE_DEC      = 3'd4,
    MODE_END      = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK,
    ST_SQ,
    ST_RES
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic fill_step;
    logic look;
    logic sq;
    logic push;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic item_fill;
    logic item_pair;
    logic fill_last;
    logic q_empty;
  } sts_t;

  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [4:0] r5;
    r5 = {2'b00, row_of(p)};
    return 3'(p - ((r5 << 2) + r5));
  endfunction

  // Step one place around the row or column, backward for decryption
  function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic dec);
    logic [2:0] w;
    if (dec) w = (v == 3'd0) ? 3'(SQ_SIDE - 1) : v - 3'd1;
    else     w = (v == 3'(SQ_SIDE - 1)) ? 3'd0 : v + 3'd1;
    return w;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    logic [4:0] r5;
    r5 = {2'b00, r};
    return (r5 << 2) + r5 + {2'b00, c};
  endfunction

endpackage

### hw/rtl/playfair_digram_cipher_top.sv
// Top level of the Playfair digram cipher: controller and datapath.
// A pair that an item closes runs through the LOOK, SQ and RES states in turn
//   (place read, square read, result push); the push waits while the previous
//   pair's results still sit in the queue. Key, clear and opening letters are
//   taken alone; key done walks all 26 letters in the FILL state. No new request
//   is taken until the walk or pair is through. The pair path is set by the
//   registered memory reads.
// Reset (rst_n low, synchronous): empties the key, held letter and result queue.
module playfair_digram_cipher_top
  import pfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [LET_W-1:0]  in_letter,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LET_W-1:0]  out_letter,
  output logic              out_last
);

  cmd_t cmd;
  sts_t sts;

  // Controller: one request at a time; stall while a pair or key walk is in flight
  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Datapath: memories, held letter and two-entry result queue.
  // The queue drains on its own, so the next request is taken while results wait.
  pfc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (in_mode),
    .in_letter  (in_letter),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_letter (out_letter),
    .out_last   (out_last)
  );

endmodule

### hw/rtl/pfc_ctrl.sv
// Sequencing state machine: accept, key fill walk, lookup stages and result push.
module pfc_ctrl
  import pfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_stall
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          if (sts.item_fill)      state_nxt = ST_FILL;
          else if (sts.item_pair) state_nxt = ST_LOOK;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) state_nxt = ST_IDLE;
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        // hold until the result queue has drained
        if (sts.q_empty) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/pfc_dp.sv
// Datapath: key square and letter place memories, held letter, pair convert, result queue.
module pfc_dp
  import pfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [LET_W-1:0] in_letter,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LET_W-1:0] out_letter,
  output logic             out_last
);

  logic [LET_W-1:0] sq_mem [0:SQ_CELLS-1];
  logic [LET_W-1:0] pl_mem [0:ALPHA-1];
  logic [ALPHA-1:0] valid_r;

  logic [LET_W-1:0] fill_r;
  logic [LET_W-1:0] fstep_r;
  logic [LET_W-1:0] held_letter_r;
  logic             held_valid_r;
  logic             held_dec_r;

  logic [LET_W-1:0] pair_a_r, pair_b_r, pair_b_nxt;
  logic             dec_r;
  logic [LET_W-1:0] qa_r, qb_r;
  logic             va_r, vb_r;
  logic [LET_W-1:0] sqa_r, sqb_r;
  logic             pass_r;

  logic [LET_W-1:0] q0_let_r, q1_let_r;
  logic             q0_last_r, q1_last_r;
  logic [1:0]       q_cnt_r;

  // item decode
  logic             needs_let, drop, mode_key, mode_enc, mode_dec, mode_end;
  logic [LET_W-1:0] lj;
  logic             enc_pair, dec_pair, end_pair;

  assign mode_key  = (in_mode == MODE_KEY);
  assign mode_enc  = (in_mode == MODE_ENC);
  assign mode_dec  = (in_mode == MODE_DEC);
  assign mode_end  = (in_mode == MODE_END);
  assign needs_let = mode_key || mode_enc || mode_dec;
  assign drop      = needs_let && (in_letter > LET_LAST);
  assign lj        = ((in_letter == LET_J) && (mode_key || mode_enc)) ? LET_I : in_letter;

  assign enc_pair = mode_enc && !drop && held_valid_r && !held_dec_r;
  assign dec_pair = mode_dec && !drop && held_valid_r && held_dec_r;
  assign end_pair = mode_end && held_valid_r && !held_dec_r;

  assign pair_b_nxt = (end_pair || (enc_pair && (held_letter_r == lj))) ? LET_X : lj;

  assign sts.item_fill = (in_mode == MODE_KEY_DONE);
  assign sts.item_pair = enc_pair || dec_pair || end_pair;
  assign sts.fill_last = (fstep_r == LET_LAST);
  assign sts.q_empty   = (q_cnt_r == 2'd0);

  // key placement: a key letter or one step of the key-done walk
  logic             put_en, do_put;
  logic [LET_W-1:0] put_let;

  always_comb begin
    if (cmd.fill_step) begin
      put_let = fstep_r;
      put_en  = (fstep_r != LET_J);
    end else begin
      put_let = lj;
      put_en  = cmd.accept && mode_key && !drop;
    end
    do_put = put_en && (fill_r < CELLS_N) && !valid_r[put_let];
  end

  always_ff @(posedge clk) begin
    if (do_put) begin
      sq_mem[fill_r]  <= put_let;
      pl_mem[put_let] <= fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      fill_r       <= '0;
      held_valid_r <= 1'b0;
      held_dec_r   <= 1'b0;
      held_letter_r <= '0;
    end else begin
      if (do_put) begin
        valid_r[put_let] <= 1'b1;
        fill_r           <= fill_r + 5'd1;
      end
      if (cmd.accept) begin
        if (in_mode == MODE_CLEAR) begin
          valid_r      <= '0;
          fill_r       <= '0;
          held_valid_r <= 1'b0;
        end else if (mode_enc && !drop) begin
          if (enc_pair) begin
            // doubled letter: the second copy opens the next pair
            if (held_letter_r != lj) held_valid_r <= 1'b0;
          end else begin
            held_letter_r <= lj;
            held_valid_r  <= 1'b1;
            held_dec_r    <= 1'b0;
          end
        end else if (mode_dec && !drop) begin
          if (dec_pair) begin
            held_valid_r <= 1'b0;
          end else begin
            held_letter_r <= lj;
            held_valid_r  <= 1'b1;
            held_dec_r    <= 1'b1;
          end
        end else if (mode_end) begin
          held_valid_r <= 1'b0;
        end
      end
    end
  end

  // key-done walk counter
  always_ff @(posedge clk) begin
    if (cmd.accept) fstep_r <= '0;
    else if (cmd.fill_step) fstep_r <= fstep_r + 5'd1;
  end

  // latch the pair
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.item_pair) begin
      pair_a_r <= held_letter_r;
      pair_b_r <= pair_b_nxt;
      dec_r    <= mode_dec;
    end
  end

  // place lookup
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      qa_r <= pl_mem[pair_a_r];
      qb_r <= pl_mem[pair_b_r];
      va_r <= valid_r[pair_a_r];
      vb_r <= valid_r[pair_b_r];
    end
  end

  // square addresses from the two places
  logic [2:0]       ra, ca, rb, cb;
  logic [LET_W-1:0] addr_a, addr_b;

  always_comb begin
    ra = row_of(qa_r);
    ca = col_of(qa_r);
    rb = row_of(qb_r);
    cb = col_of(qb_r);
    if (ra == rb) begin
      addr_a = cell_of(ra, wrap_step(ca, dec_r));
      addr_b = cell_of(rb, wrap_step(cb, dec_r));
    end else if (ca == cb) begin
      addr_a = cell_of(wrap_step(ra, dec_r), ca);
      addr_b = cell_of(wrap_step(rb, dec_r), cb);
    end else begin
      addr_a = cell_of(ra, cb);
      addr_b = cell_of(rb, ca);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sqa_r  <= sq_mem[addr_a];
      sqb_r  <= sq_mem[addr_b];
      pass_r <= !(va_r && vb_r);
    end
  end

  // results and X drop for decryption
  logic [LET_W-1:0] res_a, res_b;
  logic             ka, kb;

  assign res_a = pass_r ? pair_a_r : sqa_r;
  assign res_b = pass_r ? pair_b_r : sqb_r;
  assign ka    = !dec_r || (res_a != LET_X);
  assign kb    = !dec_r || (res_b != LET_X);

  logic pop;
  assign pop = (q_cnt_r != 2'd0) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else if (cmd.push) begin
      q_cnt_r <= {1'b0, ka} + {1'b0, kb};
    end else if (pop) begin
      q_cnt_r <= q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      q0_let_r  <= ka ? res_a : res_b;
      q0_last_r <= !(ka && kb);
      q1_let_r  <= res_b;
      q1_last_r <= 1'b1;
    end else if (pop) begin
      q0_let_r  <= q1_let_r;
      q0_last_r <= q1_last_r;
    end
  end

  assign out_valid  = (q_cnt_r != 2'd0);
  assign out_letter = q0_let_r;
  assign out_last   = q0_last_r;

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r <= 2'd2)
    else $error("result queue over two entries");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= CELLS_N)
    else $error("square fill past 25");
  a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (q_cnt_r == 2'd0))
    else $error("push into a non-empty result queue");
  a_enc_two: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !dec_r) |=> (q_cnt_r == 2'd2))
    else $error("encrypt pair did not give two results");

endmodule
